### rtl/bfct_pkg.sv
`timescale 1ns / 1ps
package bfct_pkg;

  localparam int unsigned MAX_PLANES = 6;
  localparam int unsigned DEF_PLANE_COUNT = 6;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned VEC_W = 48;
  localparam int unsigned PLANE_W = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned S2_W = 17;
  localparam int unsigned CW_W = 36;
  localparam int unsigned DOT_W = 34;
  localparam int unsigned ACC_W = 56;

  typedef logic signed [HALF_W-1:0] q_t;
  typedef logic signed [S2_W-1:0] s2_t;
  typedef logic signed [CW_W-1:0] cw_t;

  typedef struct packed {
    logic valid;
    logic cull;
    s2_t [2:0] h2;
    q_t [3:0][2:0] m;
    cw_t [2:0] cw;
  } bfct_item_t;

  function automatic q_t half_at(input logic [PLANE_W-1:0] word, input int unsigned k);
    half_at = q_t'(word[k*HALF_W +: HALF_W]);
  endfunction

endpackage

### rtl/bfct_cell.sv
`timescale 1ns / 1ps
module bfct_cell
  import bfct_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [PLANE_W-1:0]  plane,
  input  bfct_item_t          item_in,
  output bfct_item_t          item_out
);

  // Two register stages: plane dot products, then distance and radius compare.
  q_t n0, n1, n2, d;
  logic signed [DOT_W-1:0] dot_nxt [3];
  logic signed [DOT_W-1:0] dot_r [3];
  logic signed [ACC_W-1:0] dc_nxt, dc_r;
  bfct_item_t mid_r, out_r;
  bfct_item_t out_nxt;
  logic signed [ACC_W-1:0] r_sum;
  logic signed [DOT_W-1:0] mg;

  assign n0 = half_at(plane, 0);
  assign n1 = half_at(plane, 1);
  assign n2 = half_at(plane, 2);
  assign d  = half_at(plane, 3);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot_nxt[i] = DOT_W'(n0 * item_in.m[i][0]) + DOT_W'(n1 * item_in.m[i][1])
                 + DOT_W'(n2 * item_in.m[i][2]);
    end
    dc_nxt = ACC_W'(n0 * item_in.cw[0]) + ACC_W'(n1 * item_in.cw[1])
           + ACC_W'(n2 * item_in.cw[2]) + (ACC_W'(d) <<< 17);
  end

  always_comb begin
    r_sum = '0;
    for (int i = 0; i < 3; i++) begin
      mg = dot_r[i][DOT_W-1] ? -dot_r[i] : dot_r[i];
      r_sum = r_sum + ACC_W'(mid_r.h2[i] * mg);
    end
    out_nxt = mid_r;
    out_nxt.cull = mid_r.cull | (dc_r < -r_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (advance) begin
      mid_r <= item_in;
      dc_r <= dc_nxt;
      for (int i = 0; i < 3; i++) dot_r[i] <= dot_nxt[i];
      out_r <= out_nxt;
    end
  end

  assign item_out = out_r;

endmodule

### rtl/box_frustum_cull_test_core.sv
`timescale 1ns / 1ps
// Culls a box against up to six frustum planes held in configuration registers.
// The input channel takes a box (min and max corners) and its world matrix as one
// transaction; the output channel returns one culled bit per transaction, in order.
// A front stage forms the box center and half extents and moves the center into
// world space. A chain of plane cells follows, each testing one plane in two
// registered stages and passing the item to its neighbor.
// An accepted transaction passes 1 + 2 * PLANE_COUNT registers, the front
// register and then two in each cell, before it shows on out_valid.
// Throughput is one transaction per cycle while the receiver takes each output,
// set by the cell chain advancing whenever the output is empty or taken. When
// the receiver stalls, the whole chain holds; in_ready falls only while the
// output register is full and not being taken. Reset empties the chain and
// clears all plane registers to zero, so nothing is culled until planes are
// written. Planes should be written only while no transaction is in flight.
module box_frustum_cull_test_core
  import bfct_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = DEF_PLANE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VEC_W-1:0]     in_box_min,
  input  logic [VEC_W-1:0]     in_box_max,
  input  logic [VEC_W-1:0]     in_world_axis_x,
  input  logic [VEC_W-1:0]     in_world_axis_y,
  input  logic [VEC_W-1:0]     in_world_axis_z,
  input  logic [VEC_W-1:0]     in_world_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_culled,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PLANE_W-1:0]   cfg_data
);

  logic [PLANE_W-1:0] plane_r [MAX_PLANES];
  logic advance;
  bfct_item_t front_r;
  bfct_item_t chain [PLANE_COUNT+1];
  logic [VEC_W-1:0] axes [4];
  s2_t s2 [3];
  s2_t h2 [3];
  bfct_item_t front_nxt;

  assign advance = !chain[PLANE_COUNT].valid || out_ready;
  assign in_ready = advance;
  assign out_valid = chain[PLANE_COUNT].valid;
  assign out_culled = chain[PLANE_COUNT].cull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PLANES; i++) plane_r[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(MAX_PLANES))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  assign axes[0] = in_world_axis_x;
  assign axes[1] = in_world_axis_y;
  assign axes[2] = in_world_axis_z;
  assign axes[3] = in_world_offset;

  always_comb begin
    front_nxt = '0;
    front_nxt.valid = in_valid;
    for (int i = 0; i < 3; i++) begin
      s2[i] = S2_W'(half_at(PLANE_W'(in_box_min), i)) + S2_W'(half_at(PLANE_W'(in_box_max), i));
      h2[i] = S2_W'(half_at(PLANE_W'(in_box_max), i)) - S2_W'(half_at(PLANE_W'(in_box_min), i));
      front_nxt.h2[i] = h2[i];
    end
    for (int r = 0; r < 4; r++)
      for (int j = 0; j < 3; j++)
        front_nxt.m[r][j] = half_at(PLANE_W'(axes[r]), j);
    for (int j = 0; j < 3; j++)
      front_nxt.cw[j] = CW_W'(s2[0] * front_nxt.m[0][j]) + CW_W'(s2[1] * front_nxt.m[1][j])
                      + CW_W'(s2[2] * front_nxt.m[2][j]) + (CW_W'(front_nxt.m[3][j]) <<< 9);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (advance) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    bfct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .plane    (plane_r[p]),
      .item_in  (chain[p]),
      .item_out (chain[p+1])
    );
  end

endmodule

### rtl/bfct_checker.sv
`timescale 1ns / 1ps
module bfct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_culled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_culled))
    else $error("Output transaction changed while stalled.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled with empty output.");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input stalled while output drains.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind box_frustum_cull_test_core bfct_checker u_bfct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_culled (out_culled)
);

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import bfct_pkg::*;

  localparam int LATENCY = 2 * DEF_PLANE_COUNT;
  localparam int NUM_RANDOM = 1700;
  localparam int NUM_DIRECTED = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT = 3'd0, REG_RIGHT = 3'd1, REG_BOTTOM = 3'd2,
    REG_TOP = 3'd3, REG_NEAR = 3'd4, REG_FAR = 3'd5, REG_NONE = 3'd7
  } plane_reg_e;

  typedef struct {
    logic [VEC_W-1:0] bmin, bmax, ax, ay, az, off;
  } box_txn_t;

  typedef struct {
    box_txn_t box;
    logic     known;
    logic     culled;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VEC_W-1:0] in_box_min = '0, in_box_max = '0;
  logic [VEC_W-1:0] in_world_axis_x = '0, in_world_axis_y = '0;
  logic [VEC_W-1:0] in_world_axis_z = '0, in_world_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_culled;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PLANE_W-1:0] cfg_data = '0;

  box_frustum_cull_test_core dut (.*);

  logic [PLANE_W-1:0] planes [MAX_PLANES];
  logic cull_expected [$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  directed_row_t directed [NUM_DIRECTED];

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic longint sx(logic [VEC_W-1:0] v, int k);
    return longint'($signed(v[k*16 +: 16]));
  endfunction

  function automatic logic predict_culled(box_txn_t b);
    longint s2 [3], h2 [3], m [4][3], cw [3];
    longint n [3], d, dc, r, dot;
    logic [VEC_W-1:0] rows [4];
    rows[0] = b.ax; rows[1] = b.ay; rows[2] = b.az; rows[3] = b.off;
    for (int i = 0; i < 3; i++) begin
      s2[i] = sx(b.bmin, i) + sx(b.bmax, i);
      h2[i] = sx(b.bmax, i) - sx(b.bmin, i);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) m[i][j] = sx(rows[i], j);
    for (int j = 0; j < 3; j++)
      cw[j] = s2[0] * m[0][j] + s2[1] * m[1][j] + s2[2] * m[2][j] + m[3][j] * 512;
    for (int p = 0; p < DEF_PLANE_COUNT; p++) begin
      for (int j = 0; j < 3; j++) n[j] = longint'($signed(planes[p][j*16 +: 16]));
      d = longint'($signed(planes[p][63:48]));
      dc = n[0] * cw[0] + n[1] * cw[1] + n[2] * cw[2] + d * 131072;
      r = 0;
      for (int i = 0; i < 3; i++) begin
        dot = n[0] * m[i][0] + n[1] * m[i][1] + n[2] * m[i][2];
        r += h2[i] * (dot < 0 ? -dot : dot);
      end
      if (dc < -r) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cull_expected.size() == 0) report_mismatch("unexpected transaction", out_culled, 1'bx);
      else begin
        logic want;
        want = cull_expected.pop_front();
        if (out_culled !== want) report_mismatch("culled", out_culled, want);
      end
    end
  end

  // Receiver: stalls on its own pattern, with quiet stretches and one long hold.
  initial begin
    int mode;
    @(posedge clk);
    while (!stim_done || cull_expected.size() != 0) begin
      mode = $urandom_range(0, 3);
      for (int k = $urandom_range(5, 40); k > 0; k--) begin
        @(posedge clk);
        if (hold_off) out_ready <= 1'b0;
        else if (mode == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) >= mode - 1);
      end
    end
    out_ready <= 1'b1;
  end

  task automatic write_plane(plane_reg_e idx, logic [PLANE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < MAX_PLANES) planes[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cull_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_box(box_txn_t b, logic known, logic culled);
    logic want;
    in_valid <= 1'b1;
    in_box_min <= b.bmin; in_box_max <= b.bmax;
    in_world_axis_x <= b.ax; in_world_axis_y <= b.ay;
    in_world_axis_z <= b.az; in_world_offset <= b.off;
    do @(posedge clk); while (!in_ready);
    want = predict_culled(b);
    if (known && want !== culled) report_mismatch("directed row", want, culled);
    cull_expected.push_back(known ? culled : want);
  endtask

  function automatic logic [15:0] rnd_half();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rnd_vec();
    return {rnd_half(), rnd_half(), rnd_half()};
  endfunction

  function automatic logic [PLANE_W-1:0] rnd_plane();
    return {rnd_half(), rnd_half(), rnd_half(), rnd_half()};
  endfunction

  function automatic box_txn_t rnd_box();
    box_txn_t b;
    logic [15:0] lo, hi;
    b.ax = rnd_vec(); b.ay = rnd_vec(); b.az = rnd_vec(); b.off = rnd_vec();
    b.bmin = rnd_vec(); b.bmax = rnd_vec();
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 3; k++) begin
        lo = 16'($signed($urandom_range(0, 8192)) - 4096);
        hi = lo + 16'($urandom_range(0, 2048));
        b.bmin[k*16 +: 16] = lo;
        b.bmax[k*16 +: 16] = hi;
      end
    end
    return b;
  endfunction

  function automatic box_txn_t mk(logic [VEC_W-1:0] mn, mx, ax, ay, az, off);
    box_txn_t b;
    b.bmin = mn; b.bmax = mx; b.ax = ax; b.ay = ay; b.az = az; b.off = off;
    return b;
  endfunction

  localparam logic [VEC_W-1:0] ID_X = {16'h0, 16'h0, 16'h0100};
  localparam logic [VEC_W-1:0] ID_Y = {16'h0, 16'h0100, 16'h0};
  localparam logic [VEC_W-1:0] ID_Z = {16'h0100, 16'h0, 16'h0};
  localparam logic [VEC_W-1:0] ALL_MAX = {3{16'h7fff}};
  localparam logic [VEC_W-1:0] ALL_MIN = {3{16'h8000}};

  initial begin
    box_txn_t b;
    int burst;
    for (int p = 0; p < MAX_PLANES; p++) planes[p] = '0;

    // Rows 0..3 run with reset planes (never culled); the rest use the left
    // plane x >= 0 set below, so boxes wholly at negative x are culled and a
    // box touching x = 0 sits on the boundary.
    directed[0] = '{mk(ALL_MIN, ALL_MAX, ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN), 1, 0};
    directed[1] = '{mk('0, '0, '0, '0, '0, '0), 1, 0};
    directed[2] = '{mk(ALL_MAX, ALL_MIN, ID_X, ID_Y, ID_Z, ALL_MAX), 1, 0};
    directed[3] = '{mk({3{16'hffff}}, {3{16'h0001}}, ALL_MIN, ALL_MIN, ALL_MIN, '0), 1, 0};
    directed[4] = '{mk({3{16'hfe00}}, {3{16'hff00}}, ID_X, ID_Y, ID_Z, '0), 1, 1};
    directed[5] = '{mk({3{16'hfe00}}, {3{16'h0000}}, ID_X, ID_Y, ID_Z, '0), 1, 0};
    directed[6] = '{mk({3{16'h0100}}, {3{16'h0200}}, ID_X, ID_Y, ID_Z, '0), 1, 0};
    directed[7] = '{mk({3{16'h0100}}, {3{16'h0200}}, ID_X, ID_Y, ID_Z,
                       {16'h0, 16'h0, 16'hf000}), 1, 1};
    directed[8] = '{mk({3{16'h0200}}, {3{16'h0100}}, ID_X, ID_Y, ID_Z, '0), 0, 0};
    directed[9] = '{mk(ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX), 0, 0};
    directed[10] = '{mk(ALL_MIN, ALL_MIN, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MIN), 0, 0};
    directed[11] = '{mk({3{16'hff00}}, {3{16'h0100}}, ID_Y, ID_Z, ID_X, '0), 0, 0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (i == 4) begin
        in_valid <= 1'b0;
        drain();
        write_plane(REG_LEFT, {16'h0, 16'h0, 16'h0, 16'h0100});
        write_plane(REG_NONE, {4{16'h8000}});
      end
      send_box(directed[i].box, directed[i].known, directed[i].culled);
    end

    for (int phase = 0; phase < 5; phase++) begin
      in_valid <= 1'b0;
      drain();
      for (int p = 0; p < MAX_PLANES; p++) begin
        case (phase)
          0: write_plane(plane_reg_e'(p), {4{16'h7fff}});
          1: write_plane(plane_reg_e'(p), {4{16'h8000}});
          2: write_plane(plane_reg_e'(p), p == 0 ? 64'h0 : rnd_plane());
          default: write_plane(plane_reg_e'(p), rnd_plane());
        endcase
      end
      for (int k = 0; k < NUM_RANDOM / 5; k++) begin
        if (phase == 2 && k == 40) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (3 * LATENCY + 20) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        if (phase == 3 && k == 100) begin
          in_valid <= 1'b0;
          while (cull_expected.size() != 0) @(posedge clk);
        end
        burst = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 8) : 0;
        if (burst != 0) begin
          in_valid <= 1'b0;
          repeat (burst) @(posedge clk);
        end
        b = rnd_box();
        send_box(b, 1'b0, 1'b0);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    drain();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
